// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define ASSERT_IMPLIES(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Next-cycle implication, sampled on clk, off during reset.
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/core/itc_pkg.sv =====
// Types, widths and codes for the inertia tensor accumulator.
package itc_pkg;

	localparam int POS_W      = 24;             // position width, two's complement
	localparam int DR_W       = POS_W + 1;      // offset from center
	localparam int WM_W       = 16;             // mass and weight, Q8.8
	localparam int MASS_SHIFT = 8;
	localparam int FRAC_SHIFT = 12;
	localparam int M_W        = 2 * WM_W - MASS_SHIFT;  // effective mass
	localparam int MUL_W      = 33;             // shared multiplier operand width
	localparam int PROD_W     = 2 * MUL_W;
	localparam int LO_W       = 32;             // low slice of the scaled product
	localparam int T_W        = PROD_W - FRAC_SHIFT;
	localparam int TH_W       = T_W - LO_W;     // high slice, signed
	localparam int LOP_W      = LO_W + M_W;     // low partial product
	localparam int HIP_W      = TH_W + M_W;     // high partial product, signed
	localparam int FULL_W     = HIP_W + LO_W + 1;
	localparam int SH_W       = FULL_W - MASS_SHIFT;
	localparam int ACC_W      = 64;
	localparam int NUM_PAIRS  = 6;

	localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

	typedef enum logic [2:0] {
		PAIR_XX,
		PAIR_YY,
		PAIR_ZZ,
		PAIR_XY,
		PAIR_XZ,
		PAIR_YZ
	} itc_pair_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MASS,
		ST_MUL_P,
		ST_MUL_L,
		ST_MUL_H,
		ST_DRAIN_T,
		ST_DRAIN_A,
		ST_FINISH
	} itc_state_t;

	typedef struct packed {
		logic signed [POS_W-1:0] center_x;
		logic signed [POS_W-1:0] center_y;
		logic signed [POS_W-1:0] center_z;
		logic signed [POS_W-1:0] atom_x;
		logic signed [POS_W-1:0] atom_y;
		logic signed [POS_W-1:0] atom_z;
		logic [WM_W-1:0]         atom_mass;
		logic [WM_W-1:0]         atom_weight;
		logic                    last_atom;
	} itc_in_t;

	typedef struct packed {
		logic signed [ACC_W-1:0] i_xx;
		logic signed [ACC_W-1:0] i_yy;
		logic signed [ACC_W-1:0] i_zz;
		logic signed [ACC_W-1:0] i_xy;
		logic signed [ACC_W-1:0] i_xz;
		logic signed [ACC_W-1:0] i_yz;
	} itc_out_t;

	// sequencer to accumulator
	typedef struct packed {
		logic      lo_issue;   // low partial product issued this cycle
		logic      hi_issue;   // high partial product issued this cycle
		itc_pair_t pair;       // pair being worked on
		logic      finish;     // form result and clear sums
	} itc_ctrl_t;

endpackage

// ===== rtl/core/itc_mul.sv =====
// Shared signed multiplier with registered product.
module itc_mul (
	input  logic                                clk,
	input  logic signed [itc_pkg::MUL_W-1:0]    a,
	input  logic signed [itc_pkg::MUL_W-1:0]    b,
	output logic signed [itc_pkg::PROD_W-1:0]   prod
);
	import itc_pkg::*;

	always_ff @(posedge clk) begin
		prod <= a * b;
	end

endmodule

// ===== rtl/core/itc_acc.sv =====
// Term scaling, six saturating accumulators and result forming.
module itc_acc (
	input  logic                               clk,
	input  logic                               arst_n,
	input  itc_pkg::itc_ctrl_t                 ctrl,
	input  logic signed [itc_pkg::PROD_W-1:0]  prod,
	output logic                               done,
	output itc_pkg::itc_out_t                  result
);
	import itc_pkg::*;

	function automatic logic signed [ACC_W-1:0] sat_add(
		input logic signed [ACC_W-1:0] x,
		input logic signed [ACC_W-1:0] y
	);
		logic signed [ACC_W:0] s;
		s = (ACC_W+1)'(x) + (ACC_W+1)'(y);
		if (s[ACC_W] != s[ACC_W-1])
			return s[ACC_W] ? ACC_MIN : ACC_MAX;
		return s[ACC_W-1:0];
	endfunction

	function automatic logic signed [ACC_W-1:0] sat_neg(input logic signed [ACC_W-1:0] x);
		return (x == ACC_MIN) ? ACC_MAX : -x;
	endfunction

	logic                     lo_go_s1, hi_go_s1, acc_go_s2, done_q;
	itc_pair_t                idx_s1, idx_s2;
	logic [LOP_W-1:0]         lo_q;
	logic signed [ACC_W-1:0]  term_s2;
	logic signed [ACC_W-1:0]  acc_q [NUM_PAIRS];
	itc_out_t                 result_q;

	logic signed [HIP_W-1:0]  hip;
	logic signed [FULL_W-1:0] full;
	logic signed [SH_W-1:0]   sh;
	logic signed [ACC_W-1:0]  term_d;

	// q*m = hi*2^32 + lo, then floor by 256 and clamp to 64 bits
	always_comb begin
		hip  = prod[HIP_W-1:0];
		full = (FULL_W'(hip) <<< LO_W) + signed'({{(FULL_W-LOP_W){1'b0}}, lo_q});
		sh   = SH_W'(full >>> MASS_SHIFT);
		if (sh > SH_W'(ACC_MAX))
			term_d = ACC_MAX;
		else if (sh < SH_W'(ACC_MIN))
			term_d = ACC_MIN;
		else
			term_d = sh[ACC_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lo_go_s1  <= 1'b0;
			hi_go_s1  <= 1'b0;
			acc_go_s2 <= 1'b0;
			done_q    <= 1'b0;
			for (int i = 0; i < NUM_PAIRS; i++)
				acc_q[i] <= '0;
		end else begin
			lo_go_s1  <= ctrl.lo_issue;
			hi_go_s1  <= ctrl.hi_issue;
			acc_go_s2 <= hi_go_s1;
			done_q    <= ctrl.finish;
			if (acc_go_s2) begin
				acc_q[idx_s2] <= sat_add(acc_q[idx_s2], term_s2);
			end else if (ctrl.finish) begin
				for (int i = 0; i < NUM_PAIRS; i++)
					acc_q[i] <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.hi_issue)
			idx_s1 <= ctrl.pair;
		if (lo_go_s1)
			lo_q <= prod[LOP_W-1:0];
		if (hi_go_s1) begin
			term_s2 <= term_d;
			idx_s2  <= idx_s1;
		end
		if (ctrl.finish) begin
			result_q.i_xx <= sat_add(acc_q[PAIR_YY], acc_q[PAIR_ZZ]);
			result_q.i_yy <= sat_add(acc_q[PAIR_XX], acc_q[PAIR_ZZ]);
			result_q.i_zz <= sat_add(acc_q[PAIR_XX], acc_q[PAIR_YY]);
			result_q.i_xy <= sat_neg(acc_q[PAIR_XY]);
			result_q.i_xz <= sat_neg(acc_q[PAIR_XZ]);
			result_q.i_yz <= sat_neg(acc_q[PAIR_YZ]);
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

// ===== rtl/core/inertia_tensor_accumulator.sv =====
// Top level: inertia tensor accumulator on one shared multiplier.
//
//  channel | handshake        | payload
//  --------+------------------+------------------------------------
//  atom in | start / busy     | atom   (itc_in_t, one atom per beat)
//  result  | done (1 cycle)   | result (itc_out_t, on last atom only)
//
// An atom is taken when start is high and busy is low; busy then stays high
// while the shared multiplier works through it: one product for the effective
// mass, then three per moment pair (offset product, low and high slice of the
// mass scaling); the final pair is then scaled and accumulated and, on a last
// atom, the result is formed. done is registered together with the result, so
// both appear in the same cycle; the receiver cannot stall.
// Reset clears the sequencer and the six sums; no clearing pass is needed.
module inertia_tensor_accumulator (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  itc_pkg::itc_in_t  atom,
	output logic              done,
	output itc_pkg::itc_out_t result
);
	import itc_pkg::*;

	`include "assert_macros.svh"

	itc_state_t state_q, state_d;
	itc_pair_t  pair_q;

	// captured atom
	logic signed [DR_W-1:0] drx_q, dry_q, drz_q;
	logic [WM_W-1:0]        mass_q, weight_q;
	logic                   last_q;

	logic [M_W-1:0]          m_q;     // effective mass
	logic signed [TH_W-1:0]  th_q;    // high slice of floored offset product

	logic signed [MUL_W-1:0]  mul_a, mul_b;
	logic signed [PROD_W-1:0] prod;
	itc_ctrl_t                ctrl;
	logic                     accept;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pair_q  <= PAIR_XX;
			last_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept)
				last_q <= atom.last_atom;
			if (state_q == ST_MASS)
				pair_q <= PAIR_XX;
			else if (state_q == ST_MUL_H && pair_q != PAIR_YZ)
				pair_q <= itc_pair_t'(pair_q + 3'd1);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			drx_q    <= DR_W'(atom.atom_x) - DR_W'(atom.center_x);
			dry_q    <= DR_W'(atom.atom_y) - DR_W'(atom.center_y);
			drz_q    <= DR_W'(atom.atom_z) - DR_W'(atom.center_z);
			mass_q   <= atom.atom_mass;
			weight_q <= atom.atom_weight;
		end
		// mass product lands while the first offset product is issued
		if (state_q == ST_MUL_P && pair_q == PAIR_XX)
			m_q <= prod[M_W+MASS_SHIFT-1:MASS_SHIFT];
		// offset product present: keep its upper slice for the high pass
		if (state_q == ST_MUL_L)
			th_q <= prod[PROD_W-1:PROD_W-TH_W];
	end

	// sequencer and multiplier operand select
	always_comb begin
		state_d       = state_q;
		mul_a         = '0;
		mul_b         = '0;
		ctrl.lo_issue = 1'b0;
		ctrl.hi_issue = 1'b0;
		ctrl.pair     = pair_q;
		ctrl.finish   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (start)
					state_d = ST_MASS;
			end
			ST_MASS: begin
				mul_a   = MUL_W'(mass_q);
				mul_b   = MUL_W'(weight_q);
				state_d = ST_MUL_P;
			end
			ST_MUL_P: begin
				case (pair_q)
					PAIR_XX: begin
						mul_a = MUL_W'(drx_q);
						mul_b = MUL_W'(drx_q);
					end
					PAIR_YY: begin
						mul_a = MUL_W'(dry_q);
						mul_b = MUL_W'(dry_q);
					end
					PAIR_ZZ: begin
						mul_a = MUL_W'(drz_q);
						mul_b = MUL_W'(drz_q);
					end
					PAIR_XY: begin
						mul_a = MUL_W'(drx_q);
						mul_b = MUL_W'(dry_q);
					end
					PAIR_XZ: begin
						mul_a = MUL_W'(drx_q);
						mul_b = MUL_W'(drz_q);
					end
					PAIR_YZ: begin
						mul_a = MUL_W'(dry_q);
						mul_b = MUL_W'(drz_q);
					end
					default: begin
						mul_a = '0;
						mul_b = '0;
					end
				endcase
				state_d = ST_MUL_L;
			end
			ST_MUL_L: begin
				// arithmetic shift by 12 is the floor; take its low 32 bits
				mul_a         = MUL_W'(prod[FRAC_SHIFT+LO_W-1:FRAC_SHIFT]);
				mul_b         = MUL_W'(m_q);
				ctrl.lo_issue = 1'b1;
				state_d       = ST_MUL_H;
			end
			ST_MUL_H: begin
				mul_a         = MUL_W'(th_q);
				mul_b         = MUL_W'(m_q);
				ctrl.hi_issue = 1'b1;
				state_d       = (pair_q == PAIR_YZ) ? ST_DRAIN_T : ST_MUL_P;
			end
			ST_DRAIN_T: begin
				state_d = ST_DRAIN_A;
			end
			ST_DRAIN_A: begin
				state_d = last_q ? ST_FINISH : ST_IDLE;
			end
			ST_FINISH: begin
				ctrl.finish = 1'b1;
				state_d     = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	itc_mul u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	itc_acc u_acc (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.prod   (prod),
		.done   (done),
		.result (result)
	);

	`ASSERT_IMPLIES(a_done_from_finish, done, $past(state_q) == ST_FINISH)
	`ASSERT_NEXT(a_accept_starts, accept, state_q == ST_MASS)
	`ASSERT_NEXT(a_last_pair_drains, state_q == ST_MUL_H && pair_q == PAIR_YZ, state_q == ST_DRAIN_T)
	`ASSERT_IMPLIES(a_finish_only_last, state_q == ST_FINISH, last_q)

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the inertia tensor accumulator.
module tb;
	import itc_pkg::*;

	localparam logic signed [POS_W-1:0] POS_HI = {1'b0, {(POS_W-1){1'b1}}};
	localparam logic signed [POS_W-1:0] POS_LO = {1'b1, {(POS_W-1){1'b0}}};
	localparam int SETTLE_CYCLES = 40;   // idle margin after the last result beat

	logic     clk;
	logic     arst_n = 1'b0;
	logic     start = 1'b0;
	logic     busy;
	itc_in_t  atom = '0;
	logic     done;
	itc_out_t result;

	inertia_tensor_accumulator u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.atom   (atom),
		.done   (done),
		.result (result)
	);

	// atoms waiting to be driven, tensors waiting to come out
	itc_in_t  pending_atoms[$];
	itc_out_t tensor_due[$];

	// second-moment sums of the molecule in progress
	logic signed [ACC_W-1:0] mom_xx = '0, mom_yy = '0, mom_zz = '0;
	logic signed [ACC_W-1:0] mom_xy = '0, mom_xz = '0, mom_yz = '0;

	int error_count = 0;
	int taken_count = 0;
	int gap_left    = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ---------------------------------------------------------------- predictor

	function automatic logic signed [ACC_W-1:0] clamp64(input logic signed [127:0] v);
		logic signed [127:0] hi, lo;
		hi = 128'(ACC_MAX);
		lo = 128'(ACC_MIN);
		if (v > hi)
			return ACC_MAX;
		if (v < lo)
			return ACC_MIN;
		return v[ACC_W-1:0];
	endfunction

	function automatic logic signed [ACC_W-1:0] sat_add(input logic signed [ACC_W-1:0] x,
			input logic signed [ACC_W-1:0] y);
		logic signed [127:0] wx, wy;
		wx = 128'(x);
		wy = 128'(y);
		return clamp64(wx + wy);
	endfunction

	function automatic logic signed [ACC_W-1:0] sat_neg(input logic signed [ACC_W-1:0] x);
		logic signed [127:0] wx;
		wx = 128'(x);
		return clamp64(-wx);
	endfunction

	// floor(floor(da*db / 4096) * m / 256), clamped; arithmetic shifts give the floors
	function automatic logic signed [ACC_W-1:0] moment_term(input logic signed [DR_W-1:0] da,
			input logic signed [DR_W-1:0] db, input logic [M_W-1:0] m);
		logic signed [127:0] wa, wb, wm, q;
		wa = 128'(da);
		wb = 128'(db);
		wm = 128'(m);
		q  = (wa * wb) >>> FRAC_SHIFT;
		return clamp64((q * wm) >>> MASS_SHIFT);
	endfunction

	task automatic accumulate_atom(input itc_in_t a);
		logic signed [DR_W-1:0] dx, dy, dz;
		logic [2*WM_W-1:0]      mw;
		logic [M_W-1:0]         m;
		itc_out_t               tensor;
		dx = DR_W'(a.atom_x) - DR_W'(a.center_x);
		dy = DR_W'(a.atom_y) - DR_W'(a.center_y);
		dz = DR_W'(a.atom_z) - DR_W'(a.center_z);
		mw = (2*WM_W)'(a.atom_mass) * (2*WM_W)'(a.atom_weight);
		m  = M_W'(mw >> MASS_SHIFT);
		mom_xx = sat_add(mom_xx, moment_term(dx, dx, m));
		mom_yy = sat_add(mom_yy, moment_term(dy, dy, m));
		mom_zz = sat_add(mom_zz, moment_term(dz, dz, m));
		mom_xy = sat_add(mom_xy, moment_term(dx, dy, m));
		mom_xz = sat_add(mom_xz, moment_term(dx, dz, m));
		mom_yz = sat_add(mom_yz, moment_term(dy, dz, m));
		if (a.last_atom) begin
			tensor.i_xx = sat_add(mom_yy, mom_zz);
			tensor.i_yy = sat_add(mom_xx, mom_zz);
			tensor.i_zz = sat_add(mom_xx, mom_yy);
			tensor.i_xy = sat_neg(mom_xy);
			tensor.i_xz = sat_neg(mom_xz);
			tensor.i_yz = sat_neg(mom_yz);
			tensor_due.push_back(tensor);
			mom_xx = '0;
			mom_yy = '0;
			mom_zz = '0;
			mom_xy = '0;
			mom_xz = '0;
			mom_yz = '0;
		end
	endtask

	// ---------------------------------------------------------------- stimulus

	function automatic itc_in_t make_atom(input logic signed [POS_W-1:0] cx, cy, cz,
			input logic signed [POS_W-1:0] ax, ay, az, input logic [WM_W-1:0] mass,
			input logic [WM_W-1:0] weight, input logic last);
		itc_in_t a;
		a.center_x    = cx;
		a.center_y    = cy;
		a.center_z    = cz;
		a.atom_x      = ax;
		a.atom_y      = ay;
		a.atom_z      = az;
		a.atom_mass   = mass;
		a.atom_weight = weight;
		a.last_atom   = last;
		return a;
	endfunction

	function automatic logic signed [POS_W-1:0] rand_coord();
		logic signed [POS_W-1:0] c;
		c = POS_W'($urandom);
		return c;
	endfunction

	function automatic logic signed [POS_W-1:0] edge_coord();
		case ($urandom_range(0, 4))
			0:       return POS_HI;
			1:       return POS_LO;
			2:       return '0;
			3:       return '1;
			default: return 1;
		endcase
	endfunction

	// mode 0: anywhere, 1: atom close to the center, 2: range ends and values near zero
	function automatic itc_in_t rand_atom(input int mode, input logic last);
		itc_in_t a;
		int      r;
		a.center_x = rand_coord();
		a.center_y = rand_coord();
		a.center_z = rand_coord();
		a.atom_x   = rand_coord();
		a.atom_y   = rand_coord();
		a.atom_z   = rand_coord();
		if (mode == 1) begin
			a.atom_x = POS_W'(a.center_x + $urandom_range(0, 65535) - 32768);
			a.atom_y = POS_W'(a.center_y + $urandom_range(0, 65535) - 32768);
			a.atom_z = POS_W'(a.center_z + $urandom_range(0, 65535) - 32768);
		end else if (mode == 2) begin
			a.center_x = edge_coord();
			a.center_y = edge_coord();
			a.center_z = edge_coord();
			a.atom_x   = edge_coord();
			a.atom_y   = edge_coord();
			a.atom_z   = edge_coord();
		end
		r = $urandom_range(0, 9);
		a.atom_mass = (r == 0) ? 16'h0000 : (r == 1) ? 16'hFFFF : 16'($urandom);
		r = $urandom_range(0, 9);
		if (r < 6)
			a.atom_weight = 16'h0100;   // 1.0, the usual unweighted case
		else if (r == 6)
			a.atom_weight = 16'h0000;
		else if (r == 7)
			a.atom_weight = 16'hFFFF;
		else
			a.atom_weight = 16'($urandom);
		a.last_atom = last;
		return a;
	endfunction

	// Long molecule of corner offsets: each sum grows past 2^62 in magnitude, so the
	// diagonal outputs (sums of two) clamp to the positive rail.
	task automatic queue_saturating_molecule(input int count);
		itc_in_t a;
		for (int i = 0; i < count; i++) begin
			a.center_x    = POS_W'(POS_LO + $urandom_range(0, 255));
			a.atom_x      = POS_W'(POS_HI - $urandom_range(0, 255));
			a.center_y    = POS_W'(POS_HI - $urandom_range(0, 255));
			a.atom_y      = POS_W'(POS_LO + $urandom_range(0, 255));
			a.center_z    = POS_W'(POS_LO + $urandom_range(0, 255));
			a.atom_z      = POS_W'(POS_HI - $urandom_range(0, 255));
			a.atom_mass   = WM_W'(16'hFFFF - $urandom_range(0, 15));
			a.atom_weight = 16'hFFFF;
			a.last_atom   = (i == count - 1);
			pending_atoms.push_back(a);
		end
	endtask

	task automatic queue_directed();
		// all zero: empty tensor
		pending_atoms.push_back(make_atom(0, 0, 0, 0, 0, 0, 16'h0000, 16'h0000, 1'b1));
		// unit mass atom, then zero weight and zero mass atoms that add nothing
		pending_atoms.push_back(make_atom(0, 0, 0, 4096, 8192, -4096, 16'h0100, 16'h0100, 1'b0));
		pending_atoms.push_back(make_atom(0, 0, 0, 4096, 8192, -4096, 16'h1234, 16'h0000, 1'b0));
		pending_atoms.push_back(make_atom(0, 0, 0, 4096, 8192, -4096, 16'h0000, 16'hFFFF, 1'b1));
		// tiny negative products round toward minus infinity at both shifts
		pending_atoms.push_back(make_atom(0, 0, 0, -1, 1, 3, 16'h0001, 16'h0100, 1'b1));
		// widest offsets, both signs, largest effective mass
		pending_atoms.push_back(make_atom(POS_LO, POS_LO, POS_LO, POS_HI, POS_HI, POS_HI,
			16'hFFFF, 16'hFFFF, 1'b1));
		pending_atoms.push_back(make_atom(POS_HI, POS_HI, POS_HI, POS_LO, POS_LO, POS_LO,
			16'hFFFF, 16'hFFFF, 1'b1));
		pending_atoms.push_back(make_atom(POS_LO, POS_HI, 0, POS_HI, POS_LO, 0,
			16'h0100, 16'h0100, 1'b1));
		// alternating bit patterns
		pending_atoms.push_back(make_atom(24'sh555555, 24'sh555555, 24'sh555555,
			24'shAAAAAA, 24'shAAAAAA, 24'shAAAAAA, 16'hAAAA, 16'h5555, 1'b0));
		pending_atoms.push_back(make_atom(24'shAAAAAA, 24'shAAAAAA, 24'shAAAAAA,
			24'sh555555, 24'sh555555, 24'sh555555, 16'h5555, 16'hAAAA, 1'b1));
		// a short molecule near its center
		for (int i = 0; i < 4; i++)
			pending_atoms.push_back(rand_atom(1, i == 3));
		// atom on the center
		pending_atoms.push_back(make_atom(1000, -2000, 3000, 1000, -2000, 3000,
			16'hFFFF, 16'hFFFF, 1'b1));
		pending_atoms.push_back(make_atom(0, 0, 0, -1, 0, 0, 16'hFFFF, 16'hFFFF, 1'b1));
		pending_atoms.push_back(make_atom(0, 0, 0, 4095, -4097, 1, 16'h0001, 16'hFFFF, 1'b1));
	endtask

	task automatic queue_random(input int target);
		int  count, len, r, mode;
		bit  long_done;
		count     = 0;
		long_done = 0;
		while (count < target) begin
			if (!long_done && count > target / 2) begin
				queue_saturating_molecule(1100);
				long_done = 1;
			end
			r = $urandom_range(0, 99);
			len = (r < 50) ? $urandom_range(1, 3) :
				(r < 90) ? $urandom_range(4, 12) : $urandom_range(13, 40);
			for (int i = 0; i < len; i++) begin
				r = $urandom_range(0, 99);
				mode = (r < 50) ? 1 : (r < 80) ? 0 : 2;
				pending_atoms.push_back(rand_atom(mode, i == len - 1));
			end
			count += len;
		end
	endtask

	// mostly short gaps, a few long ones, and a gap-free stretch every 200 atoms
	function automatic int pick_gap(input int n);
		int r;
		if ((n % 200) < 50)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 30)
			return 0;
		if (r < 90)
			return $urandom_range(1, 25);
		return $urandom_range(26, 150);
	endfunction

	// ---------------------------------------------------------------- driver

	always @(posedge clk or negedge arst_n) begin
		int gap;
		if (!arst_n) begin
			start    <= 1'b0;
			atom     <= '0;
			gap_left <= 0;
		end else begin
			gap = gap_left;
			if (start && !busy) begin
				// beat taken at this edge
				accumulate_atom(atom);
				taken_count = taken_count + 1;
				gap = pick_gap(taken_count);
			end
			if (!(start && busy)) begin
				if (gap > 0) begin
					start    <= 1'b0;
					gap_left <= gap - 1;
				end else if (pending_atoms.size() != 0) begin
					atom     <= pending_atoms.pop_front();
					start    <= 1'b1;
					gap_left <= 0;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------- monitor

	task automatic note_error(input string msg);
		error_count++;
		if (error_count <= 10)
			$display("mismatch: %s", msg);
	endtask

	task automatic compare_field(input string name, input logic signed [ACC_W-1:0] want,
			input logic signed [ACC_W-1:0] got);
		if (got !== want)
			note_error($sformatf("%s expected %h got %h", name, want, got));
	endtask

	always @(posedge clk) begin
		itc_out_t want;
		if (arst_n && done) begin
			if (tensor_due.size() == 0) begin
				note_error("result beat with no tensor pending");
			end else begin
				want = tensor_due.pop_front();
				compare_field("i_xx", want.i_xx, result.i_xx);
				compare_field("i_yy", want.i_yy, result.i_yy);
				compare_field("i_zz", want.i_zz, result.i_zz);
				compare_field("i_xy", want.i_xy, result.i_xy);
				compare_field("i_xz", want.i_xz, result.i_xz);
				compare_field("i_yz", want.i_yz, result.i_yz);
			end
		end
	end

	// ---------------------------------------------------------------- sequence

	initial begin
		queue_directed();
		queue_random(280);
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		while (pending_atoms.size() != 0 || start)
			@(posedge clk);
		while (tensor_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (error_count == 0 && tensor_due.size() == 0) begin
			$display("inertia_tensor_accumulator verification clean");
		end else begin
			$display("inertia_tensor_accumulator verification failed");
		end
		$finish;
	end

	initial begin
		#40000000;
		$display("inertia_tensor_accumulator verification failed");
		$finish;
	end

endmodule
